// ----- design/indexed_list_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// indexed_list_engine_top_macros.svh
// Assertion macros shared by the indexed list engine RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// ile_pkg
// Types and constants shared by the indexed list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

    // List geometry.
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Port field widths.
    localparam int CMD_W     = 3;
    localparam int POS_W     = 8;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 56;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_FIND   = 3'd4,
        OP_ZERO   = 3'd5,
        OP_RESET  = 3'd6,
        OP_NOP    = 3'd7
    } ile_op_t;

    // Status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } ile_status_t;

    // Command broadcast to every cell while a token walks the row.
    typedef struct packed {
        ile_op_t               op;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] val;
        logic [CNT_W-1:0]      cnt;
    } ile_bcast_t;

    // Token handed from one cell to the next.
    typedef struct packed {
        logic                  act;
        logic [DATA_WIDTH-1:0] data;
        logic                  found;
        logic [IDX_W-1:0]      fidx;
    } ile_token_t;

endpackage

`default_nettype wire

// ----- design/indexed_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// Bounded ordered list of words held in a row of cells, one entry per cell.
//
//   channel  direction  tdata (low bit up)            tuser
//   s_*      in         position[7:0], item_value      cmd[2:0]
//   m_*      out        read_value, found,             -
//                       found_index, entry_count,
//                       status
//
// Every command sends one token down the row of DEPTH cells, one cell per
// cycle, so m_tvalid rises only after the token has left the row, and no
// new word is taken while a token walks the row.
// The next word is accepted once the result is loaded into the output
// register, even while that result still waits for m_tready.
// Reset empties the list at once; entries need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_engine_top_macros.svh"

module indexed_list_engine_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // position[7:0], item_value[39:8]
    input  wire logic [ile_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd[2:0]
    input  wire logic [ile_pkg::CMD_W-1:0]          s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // read_value[31:0], found[32], found_index[40:33], entry_count[49:41],
    // status[51:50], zero fill[55:52]
    output logic [ile_pkg::OUT_DATA_W-1:0]          m_tdata
);

    ile_pkg::ile_bcast_t            bc;
    ile_pkg::ile_token_t            tok [ile_pkg::DEPTH+1];
    logic [ile_pkg::DEPTH-1:0]      act_vec;

    // Front end and result packing.
    ile_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .bc         (bc),
        .tok_launch (tok[0]),
        .tok_exit   (tok[ile_pkg::DEPTH])
    );

    // Row of entry cells; the token moves one cell per cycle.
    for (genvar k = 0; k < ile_pkg::DEPTH; k++)
    begin : g_cell
        ile_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (ile_pkg::IDX_W'(k)),
            .bc         (bc),
            .tok_in     (tok[k]),
            .tok_out    (tok[k+1])
        );
        assign act_vec[k] = tok[k+1].act;
    end

    // Checks on the token walk and the result word.
    `ILE_ASSERT_NOW(a_single_token, 1'b1, $onehot0({act_vec, tok[0].act}),
        "more than one token in the cell row")
    `ILE_ASSERT_NOW(a_idle_row_empty, s_tready, (act_vec == '0) && !tok[0].act,
        "input ready while a token is in the cell row")
    `ILE_ASSERT_NEXT(a_accept_launch, s_tvalid && s_tready, tok[0].act,
        "accepted word did not launch a token")
    `ILE_ASSERT_NOW(a_found_in_list, m_tvalid && m_tdata[32],
        {1'b0, m_tdata[40:33]} < m_tdata[49:41],
        "found index at or past the entry count")
    `ILE_ASSERT_NOW(a_read_ok, m_tvalid && (m_tdata[31:0] != '0),
        m_tdata[51:50] == ile_pkg::STAT_OK,
        "nonzero read value with an error status")

endmodule

`default_nettype wire

// ----- design/ile_cell.sv -----
// ----------------------------------------------------------------------------
// ile_cell
// One list entry with its token stage: applies the broadcast command to its
// own entry when the token passes and hands the token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [ile_pkg::IDX_W-1:0]       cell_index,
    input  wire ile_pkg::ile_bcast_t             bc,
    input  wire ile_pkg::ile_token_t             tok_in,
    output ile_pkg::ile_token_t                  tok_out
);

    logic [ile_pkg::DATA_WIDTH-1:0] entry_reg;
    logic [ile_pkg::DATA_WIDTH-1:0] entry_next;
    logic                           act_reg;
    logic [ile_pkg::DATA_WIDTH-1:0] data_reg;
    logic [ile_pkg::DATA_WIDTH-1:0] data_next;
    logic                           found_reg;
    logic                           found_next;
    logic [ile_pkg::IDX_W-1:0]      fidx_reg;
    logic [ile_pkg::IDX_W-1:0]      fidx_next;
    logic [ile_pkg::CNT_W-1:0]      idx_c;
    logic                           pos_hit;

    assign idx_c   = ile_pkg::CNT_W'(cell_index);
    assign pos_hit = (cell_index == bc.pos);

    // Command applied to this entry while the token sits at the cell input.
    always_comb
    begin
        entry_next = entry_reg;
        data_next  = tok_in.data;
        found_next = tok_in.found;
        fidx_next  = tok_in.fidx;
        if (tok_in.act)
        begin
            unique case (bc.op)
                ile_pkg::OP_APPEND:
                begin
                    if (idx_c == bc.cnt)
                    begin
                        entry_next = bc.val;
                    end
                end
                ile_pkg::OP_INSERT:
                begin
                    // The new value lands here, or the entry below moves up.
                    if (pos_hit)
                    begin
                        entry_next = bc.val;
                        data_next  = entry_reg;
                    end
                    else if ((cell_index > bc.pos) && (idx_c <= bc.cnt))
                    begin
                        entry_next = tok_in.data;
                        data_next  = entry_reg;
                    end
                end
                ile_pkg::OP_READ:
                begin
                    if (pos_hit)
                    begin
                        data_next = entry_reg;
                    end
                end
                ile_pkg::OP_WRITE:
                begin
                    if (pos_hit)
                    begin
                        entry_next = bc.val;
                    end
                end
                ile_pkg::OP_FIND:
                begin
                    // Only the first match along the row is recorded.
                    if (!tok_in.found && (idx_c < bc.cnt) && (entry_reg == bc.val))
                    begin
                        found_next = 1'b1;
                        fidx_next  = cell_index;
                    end
                end
                ile_pkg::OP_ZERO:
                begin
                    if (idx_c < bc.cnt)
                    begin
                        entry_next = '0;
                    end
                end
                ile_pkg::OP_RESET, ile_pkg::OP_NOP:
                begin
                end
            endcase
        end
    end

    // Token presence bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= tok_in.act;
        end
    end

    // Entry and token payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        data_reg  <= data_next;
        found_reg <= found_next;
        fidx_reg  <= fidx_next;
    end

    assign tok_out.act   = act_reg;
    assign tok_out.data  = data_reg;
    assign tok_out.found = found_reg;
    assign tok_out.fidx  = fidx_reg;

endmodule

`default_nettype wire

// ----- design/ile_ctrl.sv -----
// ----------------------------------------------------------------------------
// ile_ctrl
// Command front end: checks the command against the count, launches a token
// into the cell row and packs the result word when the token leaves it.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [ile_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic [ile_pkg::CMD_W-1:0]          s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [ile_pkg::OUT_DATA_W-1:0]          m_tdata,
    output ile_pkg::ile_bcast_t                     bc,
    output ile_pkg::ile_token_t                     tok_launch,
    input  wire ile_pkg::ile_token_t                tok_exit
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } ile_state_t;

    ile_state_t                         state_reg;
    ile_state_t                         state_next;
    logic [ile_pkg::CNT_W-1:0]          count_reg;
    logic [ile_pkg::CNT_W-1:0]          count_next;
    logic                               launch_reg;
    logic                               launch_next;
    logic                               m_tvalid_reg;
    logic                               m_tvalid_next;
    logic [ile_pkg::OUT_DATA_W-1:0]     m_tdata_reg;
    logic [ile_pkg::OUT_DATA_W-1:0]     m_tdata_next;
    ile_pkg::ile_bcast_t                bc_reg;
    ile_pkg::ile_bcast_t                bc_next;
    ile_pkg::ile_status_t               stat_reg;
    ile_pkg::ile_status_t               stat_next;
    logic [ile_pkg::DATA_WIDTH-1:0]     res_data_reg;
    logic                               res_found_reg;
    logic [ile_pkg::IDX_W-1:0]          res_fidx_reg;

    logic                               accept;
    logic                               out_free;
    ile_pkg::ile_op_t                   op_in;
    logic [ile_pkg::POS_W-1:0]          pos_in;
    logic [ile_pkg::CNT_W-1:0]          pos_c;
    logic                               full;
    logic [ile_pkg::VAL_W-1:0]          read_word;

    assign accept   = s_tvalid && (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign op_in    = ile_pkg::ile_op_t'(s_tuser);
    assign pos_in   = s_tdata[ile_pkg::POS_W-1:0];
    assign pos_c    = ile_pkg::CNT_W'(pos_in);
    assign full     = (count_reg == ile_pkg::CNT_W'(ile_pkg::DEPTH));

    // Check the command, settle the new count and the command the row sees.
    always_comb
    begin
        count_next = count_reg;
        stat_next  = stat_reg;
        bc_next    = bc_reg;
        if (accept)
        begin
            stat_next  = ile_pkg::STAT_OK;
            bc_next.op  = op_in;
            bc_next.pos = pos_in[ile_pkg::IDX_W-1:0];
            bc_next.val = s_tdata[ile_pkg::POS_W +: ile_pkg::DATA_WIDTH];
            bc_next.cnt = count_reg;
            unique case (op_in)
                ile_pkg::OP_APPEND:
                begin
                    if (full)
                    begin
                        stat_next  = ile_pkg::STAT_FULL;
                        bc_next.op = ile_pkg::OP_NOP;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                ile_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        stat_next  = ile_pkg::STAT_FULL;
                        bc_next.op = ile_pkg::OP_NOP;
                    end
                    else if (pos_c > count_reg)
                    begin
                        stat_next  = ile_pkg::STAT_RANGE;
                        bc_next.op = ile_pkg::OP_NOP;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                ile_pkg::OP_READ, ile_pkg::OP_WRITE:
                begin
                    if (pos_c >= count_reg)
                    begin
                        stat_next  = ile_pkg::STAT_RANGE;
                        bc_next.op = ile_pkg::OP_NOP;
                    end
                end
                ile_pkg::OP_RESET:
                begin
                    count_next = '0;
                    bc_next.op = ile_pkg::OP_NOP;
                end
                ile_pkg::OP_FIND, ile_pkg::OP_ZERO, ile_pkg::OP_NOP:
                begin
                end
            endcase
        end
    end

    // Sequencer: wait for a word, walk the row, hand over the result.
    always_comb
    begin
        state_next    = state_reg;
        launch_next   = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_WALK;
                    launch_next = 1'b1;
                end
            end
            S_WALK:
            begin
                if (tok_exit.act)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        {(ile_pkg::OUT_DATA_W - 52){1'b0}},
                        stat_reg,
                        count_reg,
                        ile_pkg::POS_W'(res_fidx_reg),
                        res_found_reg,
                        read_word
                    };
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Only a read that passed the range check carries an entry back.
    assign read_word = (bc_reg.op == ile_pkg::OP_READ) ?
                       ile_pkg::VAL_W'(res_data_reg) : '0;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            launch_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            launch_reg   <= launch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Command, result and output payload.
    always_ff @(posedge clk)
    begin
        bc_reg      <= bc_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
        if (tok_exit.act)
        begin
            res_data_reg  <= tok_exit.data;
            res_found_reg <= tok_exit.found;
            res_fidx_reg  <= tok_exit.fidx;
        end
    end

    assign s_tready         = (state_reg == S_IDLE);
    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = m_tdata_reg;
    assign bc               = bc_reg;
    assign tok_launch.act   = launch_reg;
    assign tok_launch.data  = '0;
    assign tok_launch.found = 1'b0;
    assign tok_launch.fidx  = '0;

endmodule

`default_nettype wire
